// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// File: rtl/qte_pkg.sv
package qte_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int CORDIC_STEPS_DEFAULT = 16;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] qx;
        logic signed [SAMPLE_BITS-1:0] qy;
        logic signed [SAMPLE_BITS-1:0] qz;
        logic signed [SAMPLE_BITS-1:0] qw;
    } quat_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] roll_angle;
        logic signed [SAMPLE_BITS-1:0] pitch_angle;
        logic signed [SAMPLE_BITS-1:0] yaw_angle;
        logic                          pitch_clamped;
    } euler_t;

    // Arctangent of 2^-i as a 32-bit binary angle (2^32 per turn).
    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] a;
        case (i)
            5'd0:  a = 32'd536870912;
            5'd1:  a = 32'd316933406;
            5'd2:  a = 32'd167458907;
            5'd3:  a = 32'd85004756;
            5'd4:  a = 32'd42667331;
            5'd5:  a = 32'd21354465;
            5'd6:  a = 32'd10679838;
            5'd7:  a = 32'd5340245;
            5'd8:  a = 32'd2670163;
            5'd9:  a = 32'd1335087;
            5'd10: a = 32'd667544;
            5'd11: a = 32'd333772;
            5'd12: a = 32'd166886;
            5'd13: a = 32'd83443;
            5'd14: a = 32'd41722;
            5'd15: a = 32'd20861;
            5'd16: a = 32'd10430;
            5'd17: a = 32'd5215;
            5'd18: a = 32'd2608;
            5'd19: a = 32'd1304;
            5'd20: a = 32'd652;
            5'd21: a = 32'd326;
            5'd22: a = 32'd163;
            5'd23: a = 32'd81;
            5'd24: a = 32'd41;
            5'd25: a = 32'd20;
            5'd26: a = 32'd10;
            5'd27: a = 32'd5;
            5'd28: a = 32'd3;
            5'd29: a = 32'd1;
            5'd30: a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

// File: rtl/qte_cordic.sv
module qte_cordic
    import qte_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEFAULT
)
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [34:0] y_in,
    input  logic signed [34:0] x_in,
    output logic [31:0]        angle
);

    logic signed [36:0] x_reg [0:STEPS];
    logic signed [36:0] y_reg [0:STEPS];
    logic [31:0]        ang_reg [0:STEPS];
    logic               zero_reg [0:STEPS];

    logic signed [36:0] x_next;
    logic signed [36:0] y_next;
    logic [31:0]        ang_next;

    // A vector in the left half plane is first turned by a quarter turn.
    always_comb
    begin
        x_next   = 37'(x_in);
        y_next   = 37'(y_in);
        ang_next = '0;
        if (x_in < 0)
        begin
            if (y_in >= 0)
            begin
                x_next   = 37'(y_in);
                y_next   = -37'(x_in);
                ang_next = 32'h4000_0000;
            end
            else
            begin
                x_next   = -37'(y_in);
                y_next   = 37'(x_in);
                ang_next = 32'hC000_0000;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x_next;
            y_reg[0]    <= y_next;
            ang_reg[0]  <= ang_next;
            zero_reg[0] <= (x_in == 0) && (y_in == 0);
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_reg[i] < 0)
                begin
                    x_reg[i+1]   <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1]   <= y_reg[i] + (x_reg[i] >>> i);
                    ang_reg[i+1] <= ang_reg[i] - atan_entry(5'(i));
                end
                else
                begin
                    x_reg[i+1]   <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1]   <= y_reg[i] - (x_reg[i] >>> i);
                    ang_reg[i+1] <= ang_reg[i] + atan_entry(5'(i));
                end
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    assign angle = zero_reg[STEPS] ? '0 : ang_reg[STEPS];

endmodule

// File: rtl/quaternion_to_euler_core.sv
// Quaternion to ZYX Euler angle converter.
// Requests on the sample channel carry one quaternion (qx, qy, qz, qw) in
// signed Q1.15; requests on the angles channel carry roll, pitch and yaw as
// binary angles (32768 stands for pi) and a flag that the pitch sine was
// clamped to unit magnitude.
// From acceptance to the result appearing on the angles channel, a request
// passes through registers for the products, the sums and the square, the
// square root stages (one result bit per stage), the arctangent units and
// the rounding into the output register.
// Throughput is one request per cycle while no stall holds the pipeline;
// every stage is a register with a valid bit moving alongside.
// Reset clears the valid bits only, so the pipeline comes up empty.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and sample_stall is raised; nothing is lost or repeated.
`include "assert_macros.svh"

module quaternion_to_euler_core
    import qte_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   sample_valid,
    output logic   sample_stall,
    input  quat_t  sample,
    output logic   angle_valid,
    input  logic   angle_stall,
    output euler_t angles
);

    localparam int LAT = CORDIC_STEPS + 36;
    localparam int RT  = 31;

    logic           en;
    logic [LAT-1:0] vld_reg;

    assign en           = !(vld_reg[LAT-1] && angle_stall);
    assign sample_stall = !en;
    assign angle_valid  = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], sample_valid};
    end

    // Products in Q.30.
    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, wz_reg;
    logic signed [31:0] xy_reg, zz_reg, wy_reg, zx_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx_reg <= sample.qw * sample.qx;
            yz_reg <= sample.qy * sample.qz;
            xx_reg <= sample.qx * sample.qx;
            yy_reg <= sample.qy * sample.qy;
            wz_reg <= sample.qw * sample.qz;
            xy_reg <= sample.qx * sample.qy;
            zz_reg <= sample.qz * sample.qz;
            wy_reg <= sample.qw * sample.qy;
            zx_reg <= sample.qz * sample.qx;
        end
    end

    localparam logic signed [34:0] ONE = 35'sd1 <<< 30;

    logic signed [34:0] sr_next, cr_next, sy_next, cy_next, sp_next;
    logic signed [31:0] spc_next;
    logic               clamp_next;

    always_comb
    begin
        sr_next = (35'(wx_reg) + 35'(yz_reg)) <<< 1;
        cr_next = ONE - ((35'(xx_reg) + 35'(yy_reg)) <<< 1);
        sy_next = (35'(wz_reg) + 35'(xy_reg)) <<< 1;
        cy_next = ONE - ((35'(yy_reg) + 35'(zz_reg)) <<< 1);
        sp_next = (35'(wy_reg) - 35'(zx_reg)) <<< 1;
        clamp_next = 1'b0;
        spc_next   = 32'(sp_next);
        if (sp_next > ONE)
        begin
            spc_next   = 32'(ONE);
            clamp_next = 1'b1;
        end
        else if (sp_next < -ONE)
        begin
            spc_next   = -32'(ONE);
            clamp_next = 1'b1;
        end
    end

    logic signed [34:0] sr_reg, cr_reg, sy_reg, cy_reg;
    logic signed [31:0] sp_reg;
    logic               clamp_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sr_reg    <= sr_next;
            cr_reg    <= cr_next;
            sy_reg    <= sy_next;
            cy_reg    <= cy_next;
            sp_reg    <= spc_next;
            clamp_reg <= clamp_next;
        end
    end

    // Square of the clamped pitch sine.
    logic [30:0] mag_next;
    logic [61:0] sq_reg;
    logic signed [34:0] sr3_reg, cr3_reg, sy3_reg, cy3_reg;
    logic signed [31:0] sp3_reg;
    logic               clamp3_reg;

    assign mag_next = sp_reg[31] ? 31'(-sp_reg) : sp_reg[30:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg     <= mag_next * mag_next;
            sr3_reg    <= sr_reg;
            cr3_reg    <= cr_reg;
            sy3_reg    <= sy_reg;
            cy3_reg    <= cy_reg;
            sp3_reg    <= sp_reg;
            clamp3_reg <= clamp_reg;
        end
    end

    // Square root of 2^60 - s^2, one result bit per stage.
    logic [61:0]        v_reg   [0:RT-1];
    logic [61:0]        res_reg [0:RT-1];
    logic signed [34:0] csr_reg [0:RT-1];
    logic signed [34:0] ccr_reg [0:RT-1];
    logic signed [34:0] csy_reg [0:RT-1];
    logic signed [34:0] ccy_reg [0:RT-1];
    logic signed [31:0] csp_reg [0:RT-1];
    logic               ccl_reg [0:RT-1];

    for (genvar k = 0; k < RT; k++)
    begin : g_sqrt
        localparam logic [61:0] BIT = 62'd1 << (60 - 2 * k);
        logic [61:0]        v_in, res_in, t;
        logic signed [34:0] sr_in, cr_in, sy_in, cy_in;
        logic signed [31:0] sp_in;
        logic               cl_in;

        if (k == 0)
        begin : g_first
            assign v_in   = (62'd1 << 60) - sq_reg;
            assign res_in = '0;
            assign sr_in  = sr3_reg;
            assign cr_in  = cr3_reg;
            assign sy_in  = sy3_reg;
            assign cy_in  = cy3_reg;
            assign sp_in  = sp3_reg;
            assign cl_in  = clamp3_reg;
        end
        else
        begin : g_rest
            assign v_in   = v_reg[k-1];
            assign res_in = res_reg[k-1];
            assign sr_in  = csr_reg[k-1];
            assign cr_in  = ccr_reg[k-1];
            assign sy_in  = csy_reg[k-1];
            assign cy_in  = ccy_reg[k-1];
            assign sp_in  = csp_reg[k-1];
            assign cl_in  = ccl_reg[k-1];
        end

        assign t = res_in + BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (v_in >= t)
                begin
                    v_reg[k]   <= v_in - t;
                    res_reg[k] <= (res_in >> 1) + BIT;
                end
                else
                begin
                    v_reg[k]   <= v_in;
                    res_reg[k] <= res_in >> 1;
                end
                csr_reg[k] <= sr_in;
                ccr_reg[k] <= cr_in;
                csy_reg[k] <= sy_in;
                ccy_reg[k] <= cy_in;
                csp_reg[k] <= sp_in;
                ccl_reg[k] <= cl_in;
            end
        end
    end

    logic signed [34:0] cp_next;
    logic [31:0]        roll_ang, pitch_ang, yaw_ang;

    assign cp_next = $signed({4'b0, res_reg[RT-1][30:0]});

    qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll
    (
        .clk   (clk),
        .en    (en),
        .y_in  (csr_reg[RT-1]),
        .x_in  (ccr_reg[RT-1]),
        .angle (roll_ang)
    );

    qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch
    (
        .clk   (clk),
        .en    (en),
        .y_in  (35'(csp_reg[RT-1])),
        .x_in  (cp_next),
        .angle (pitch_ang)
    );

    qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw
    (
        .clk   (clk),
        .en    (en),
        .y_in  (csy_reg[RT-1]),
        .x_in  (ccy_reg[RT-1]),
        .angle (yaw_ang)
    );

    logic clamp_dly_reg [0:CORDIC_STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            clamp_dly_reg[0] <= ccl_reg[RT-1];
            for (int i = 0; i < CORDIC_STEPS; i++)
                clamp_dly_reg[i+1] <= clamp_dly_reg[i];
        end
    end

    // Round each 32-bit angle to the output width, then limit pitch.
    localparam int SH = 32 - SAMPLE_BITS;
    localparam logic [31:0] HALF = 32'd1 << (SH - 1);
    localparam logic signed [SAMPLE_BITS-1:0] LIM = SAMPLE_BITS'(1 << (SAMPLE_BITS - 2));

    logic [31:0]                   roll_rnd, pitch_rnd, yaw_rnd;
    logic signed [SAMPLE_BITS-1:0] pitch_s;
    euler_t                        angles_next;
    euler_t                        angles_reg;

    always_comb
    begin
        roll_rnd  = (roll_ang + HALF) >> SH;
        pitch_rnd = (pitch_ang + HALF) >> SH;
        yaw_rnd   = (yaw_ang + HALF) >> SH;
        pitch_s   = pitch_rnd[SAMPLE_BITS-1:0];
        if (pitch_s > LIM)
            pitch_s = LIM;
        else if (pitch_s < -LIM)
            pitch_s = -LIM;
        angles_next.roll_angle    = roll_rnd[SAMPLE_BITS-1:0];
        angles_next.pitch_angle   = pitch_s;
        angles_next.yaw_angle     = yaw_rnd[SAMPLE_BITS-1:0];
        angles_next.pitch_clamped = clamp_dly_reg[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            angles_reg <= angles_next;
    end

    assign angles = angles_reg;

    `ASSERT_ALWAYS(a_pitch_range, !angle_valid || (angles.pitch_angle <= LIM && angles.pitch_angle >= -LIM), "pitch outside quarter turn")
    `ASSERT_ALWAYS(a_stall_cause, !sample_stall || (angle_valid && angle_stall), "input stalled without a held result")
    `ASSERT_NEXT(a_hold, !en, $stable(vld_reg) && $stable(angles_reg), "pipeline moved while stalled")

endmodule

// File: dv/quaternion_to_euler_core_tb.sv
module quaternion_to_euler_core_tb
    import qte_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS = CORDIC_STEPS_DEFAULT;
    localparam int LATENCY = STEPS + 36;
    localparam int IDLE_LIMIT = 20000;
    localparam logic signed [63:0] ONE_Q30 = 64'sd1 << 30;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   sample_valid = 1'b0;
    logic   sample_stall;
    quat_t  sample = '0;
    logic   angle_valid;
    logic   angle_stall = 1'b0;
    euler_t angles;

    euler_t expected_angles[$];
    int     errors = 0;
    int     quats_sent = 0;
    int     angles_seen = 0;
    int     clamps_seen = 0;
    int     idle_cycles = 0;
    bit     stimulus_done = 1'b0;

    quaternion_to_euler_core #(.CORDIC_STEPS(STEPS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample(sample),
        .angle_valid(angle_valid),
        .angle_stall(angle_stall),
        .angles(angles)
    );

    always #5 clk = ~clk;

    // The table of arctangents is held here rather than taken from the package.
    function automatic logic [31:0] atan_step(input int i);
        logic [31:0] tab [0:15];
        tab = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
                32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
                32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
                32'd166886, 32'd83443, 32'd41722, 32'd20861};
        return (i < 16) ? tab[i] : 32'd0;
    endfunction

    function automatic logic [31:0] vector_angle(input logic signed [63:0] y_in,
                                                 input logic signed [63:0] x_in);
        logic signed [63:0] x, y, dx, dy, t;
        logic [31:0] acc;
        x = x_in;
        y = y_in;
        acc = '0;
        if (x == 0 && y == 0)
            return 32'd0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; acc = 32'h4000_0000;
            end
            else
            begin
                x = -y; y = t; acc = 32'hC000_0000;
            end
        end
        for (int i = 0; i < STEPS && i < 31; i++)
        begin
            dx = x >>> i;
            dy = y >>> i;
            if (y < 0)
            begin
                x = x - dy; y = y + dx; acc = acc - atan_step(i);
            end
            else
            begin
                x = x + dy; y = y - dx; acc = acc + atan_step(i);
            end
        end
        return acc;
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v_in);
        logic [63:0] v, root, b;
        v = v_in;
        root = '0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= root + b)
            begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic logic signed [15:0] round_angle(input logic [31:0] a);
        logic [31:0] r;
        r = (a + 32'h0000_8000) >> 16;
        return r[15:0];
    endfunction

    // Products are exact in Q.30 at 16-bit samples, so no rescaling is needed.
    function automatic euler_t predict_angles(input quat_t q);
        logic signed [63:0] x, y, z, w, sr, cr, sy, cy, sp, mag;
        logic signed [63:0] pitch;
        logic [63:0] cp;
        euler_t e;
        x = q.qx; y = q.qy; z = q.qz; w = q.qw;
        e.pitch_clamped = 1'b0;
        sr = 2 * (w * x + y * z);
        cr = ONE_Q30 - 2 * (x * x + y * y);
        sy = 2 * (w * z + x * y);
        cy = ONE_Q30 - 2 * (y * y + z * z);
        sp = 2 * (w * y - z * x);
        if (sp > ONE_Q30)
        begin
            sp = ONE_Q30; e.pitch_clamped = 1'b1;
        end
        if (sp < -ONE_Q30)
        begin
            sp = -ONE_Q30; e.pitch_clamped = 1'b1;
        end
        mag = (sp < 0) ? -sp : sp;
        cp = floor_sqrt((64'd1 << 60) - mag * mag);
        pitch = round_angle(vector_angle(sp, $signed(cp)));
        if (pitch > 16384)
            pitch = 16384;
        if (pitch < -16384)
            pitch = -16384;
        e.roll_angle = round_angle(vector_angle(sr, cr));
        e.pitch_angle = pitch[15:0];
        e.yaw_angle = round_angle(vector_angle(sy, cy));
        return e;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_quat(input quat_t q);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= q;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        expected_angles.push_back(predict_angles(q));
        quats_sent++;
    endtask

    function automatic quat_t make_quat(input int a, input int b, input int c, input int d);
        quat_t q;
        q.qx = a[15:0]; q.qy = b[15:0]; q.qz = c[15:0]; q.qw = d[15:0];
        return q;
    endfunction

    // Axis-aligned orientations, half turns, the zero vector and full-scale corners.
    task automatic test_directed();
        send_quat(make_quat(0, 0, 0, 32767));
        send_quat(make_quat(0, 0, 0, 0));
        send_quat(make_quat(32767, 0, 0, 0));
        send_quat(make_quat(0, 32767, 0, 0));
        send_quat(make_quat(0, 0, 32767, 0));
        send_quat(make_quat(-32768, 0, 0, 0));
        send_quat(make_quat(0, -32768, 0, 0));
        send_quat(make_quat(0, 0, -32768, 0));
        send_quat(make_quat(0, 0, 0, -32768));
        send_quat(make_quat(23170, 0, 0, 23170));
        send_quat(make_quat(0, 23170, 0, 23170));
        send_quat(make_quat(0, -23170, 0, 23170));
        send_quat(make_quat(0, 0, 23170, 23170));
        send_quat(make_quat(0, 23170, -23170, 0));
        send_quat(make_quat(0, 23400, 0, 23400));
        send_quat(make_quat(0, -23400, 0, 23400));
        send_quat(make_quat(-32768, -32768, -32768, -32768));
        send_quat(make_quat(32767, 32767, 32767, 32767));
        send_quat(make_quat(32767, -32768, 32767, -32768));
        send_quat(make_quat(16384, 16384, 16384, 16384));
        send_quat(make_quat(0, 0, 1, 0));
        send_quat(make_quat(0, 0, 0, 1));
    endtask

    // Mostly near-unit quaternions so that angles sweep the whole circle.
    task automatic test_random_unit();
        int a, b, c, d;
        longint n2;
        repeat (1400)
        begin
            a = $signed($urandom_range(0, 65535) - 32768);
            b = $signed($urandom_range(0, 65535) - 32768);
            c = $signed($urandom_range(0, 65535) - 32768);
            d = $signed($urandom_range(0, 65535) - 32768);
            n2 = longint'(a) * a + longint'(b) * b + longint'(c) * c + longint'(d) * d;
            if (n2 > 0)
            begin
                a = int'(real'(a) * 32767.0 / $sqrt(real'(n2)));
                b = int'(real'(b) * 32767.0 / $sqrt(real'(n2)));
                c = int'(real'(c) * 32767.0 / $sqrt(real'(n2)));
                d = int'(real'(d) * 32767.0 / $sqrt(real'(n2)));
            end
            send_quat(make_quat(a, b, c, d));
        end
    endtask

    // Raw words, including non-unit and heavily clamped cases.
    task automatic test_random_raw();
        quat_t q;
        repeat (400)
        begin
            q = {$urandom, $urandom};
            send_quat(q);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            angle_stall <= ($urandom_range(0, 99) < 20) ||
                           (angle_stall && $urandom_range(0, 99) < 70);
    end

    always @(posedge clk)
    begin
        euler_t want;
        if (rst_n && angle_valid && !angle_stall)
        begin
            angles_seen++;
            if (angles.pitch_clamped)
                clamps_seen++;
            if (expected_angles.size() == 0)
            begin
                $error("unexpected result: %p", angles);
                errors++;
            end
            else
            begin
                want = expected_angles.pop_front();
                if (angles.roll_angle !== want.roll_angle)
                begin
                    $error("roll_angle: expected %0d, got %0d",
                           want.roll_angle, angles.roll_angle);
                    errors++;
                end
                if (angles.pitch_angle !== want.pitch_angle)
                begin
                    $error("pitch_angle: expected %0d, got %0d",
                           want.pitch_angle, angles.pitch_angle);
                    errors++;
                end
                if (angles.yaw_angle !== want.yaw_angle)
                begin
                    $error("yaw_angle: expected %0d, got %0d",
                           want.yaw_angle, angles.yaw_angle);
                    errors++;
                end
                if (angles.pitch_clamped !== want.pitch_clamped)
                begin
                    $error("pitch_clamped: expected %0b, got %0b",
                           want.pitch_clamped, angles.pitch_clamped);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (angle_valid && !angle_stall))
            idle_cycles <= 0;
        else if (rst_n && (!stimulus_done || expected_angles.size() != 0))
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no request moved for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_unit();
        test_random_raw();
        sample_valid <= 1'b0;
        stimulus_done = 1'b1;
        while (expected_angles.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        $display("Sent %0d quaternions; %0d angle sets checked, %0d with pitch clamped.",
                 quats_sent, angles_seen, clamps_seen);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
